/* hdl/lsht_pkg.sv */
// Shared types, constants and helpers for the listening-socket hash table.
package lsht_pkg;

    localparam int TABLE_SIZE  = 64;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int PTR_W       = SLOT_W + 1;
    localparam int BL_DEPTH    = 16;
    localparam int BL_IDX_W    = $clog2(BL_DEPTH);
    localparam int BL_CNT_W    = BL_IDX_W + 1;
    localparam int BL_ADDR_W   = SLOT_W + BL_IDX_W;
    localparam int HASH_STEPS  = 7;
    localparam int HSTEP_W     = $clog2(HASH_STEPS);

    localparam logic [PTR_W-1:0] NONE    = PTR_W'(TABLE_SIZE);
    localparam logic [31:0]      JH_INIT = 32'hDEAD_BEF5;
    localparam logic [7:0]       REF_MAX = 8'hFF;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_LOOKUP  = 3'd1,
        OP_CLOSE   = 3'd2,
        OP_RELEASE = 3'd3,
        OP_PUSH    = 3'd4,
        OP_POP     = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EXISTS   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_BADSLOT  = 3'd4,
        STAT_BLFULL   = 3'd5,
        STAT_BLEMPTY  = 3'd6,
        STAT_REFFULL  = 3'd7
    } status_t;

    typedef struct packed {
        logic [31:0]         key_addr;
        logic [15:0]         key_port;
        logic [PTR_W-1:0]    next;
        logic [PTR_W-1:0]    prev;
        logic [PTR_W-1:0]    home;
        logic [7:0]          ref_cnt;
        logic [PTR_W-1:0]    free_next;
        logic [BL_IDX_W-1:0] bl_rd;
        logic [BL_CNT_W-1:0] bl_cnt;
    } rec_t;

    typedef enum logic [2:0] {
        PTR_HOLD, PTR_INC, PTR_HEAD, PTR_NEXT, PTR_SLOT, PTR_FREE, PTR_PV, PTR_NX
    } ptr_sel_t;

    typedef enum logic [3:0] {
        W_NONE, W_CLEAR, W_CREATE, W_REF_INC, W_REF_DEC, W_SET_PREV_F,
        W_SET_NEXT_NX, W_SET_PREV_PV, W_UNLINK_SELF, W_BL_PUSH, W_BL_POP, W_FREE
    } wr_sel_t;

    typedef enum logic [1:0] {
        B_NONE, B_CLEAR, B_CREATE, B_UNLINK
    } bkt_wr_t;

    typedef enum logic [1:0] {
        FH_HOLD, FH_POP, FH_PUSH
    } fh_sel_t;

    typedef enum logic [3:0] {
        EM_NONE, EM_LOOKUP_OK, EM_REFFULL, EM_MISS, EM_EXISTS, EM_FULL, EM_CREATED,
        EM_BADSLOT, EM_BLFULL, EM_PUSHED, EM_BLEMPTY, EM_POPPED, EM_DROPPED,
        EM_FLUSH, EM_FREED
    } emit_t;

    typedef struct packed {
        logic     capture;
        logic     hash_step;
        ptr_sel_t ptr_sel;
        wr_sel_t  wr_sel;
        bkt_wr_t  bkt_wr;
        fh_sel_t  fh_sel;
        logic     fslot_load;
        logic     sav_load;
        logic     bl_push;
        emit_t    emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic hash_last;
        logic head_none;
        logic key_match;
        logic next_none;
        logic ref_zero;
        logic ref_one;
        logic ref_full;
        logic bl_full;
        logic bl_empty;
        logic linked;
        logic pv_none;
        logic sav_nx_none;
        logic free_none;
        logic out_free;
        logic clr_last;
    } stat_t;

    typedef enum logic [4:0] {
        CS_CLEAR, CS_IDLE, CS_DISPATCH, CS_HASH, CS_H_WAIT, CS_H_CHK, CS_WK_WAIT,
        CS_WK_CMP, CS_FOUND, CS_MISS, CS_C_WAIT, CS_C_WR, CS_C_HWAIT, CS_C_HWR,
        CS_C_EMIT, CS_S_WAIT, CS_S_CHK, CS_P_EMIT, CS_DROP, CS_F_CHK, CS_F_EMIT,
        CS_U_CHK, CS_U_PV_WAIT, CS_U_PV_WR, CS_U_NX, CS_U_NX_WAIT, CS_U_NX_WR,
        CS_U_SELF, CS_U_SELF_WAIT, CS_U_SELF_WR, CS_FREE
    } ctrl_state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        return (x << r) | (x >> (6'd32 - {1'b0, r}));
    endfunction

endpackage

/* hdl/lsht_dpath.sv */
// Datapath: slot records, bucket heads, backlog store, hash unit and result register.
module lsht_dpath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lsht_pkg::cmd_t              cmd,
    output lsht_pkg::stat_t             stat,
    input  logic [2:0]                  op,
    input  logic [31:0]                 addr,
    input  logic [15:0]                 port,
    input  logic [5:0]                  slot,
    input  logic [15:0]                 conn,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [5:0]                  slot_out,
    output logic [15:0]                 conn_out,
    output logic                        flushed,
    output logic                        freed,
    output logic [4:0]                  pending,
    output logic                        last
);

    localparam int SW = lsht_pkg::SLOT_W;
    localparam int PW = lsht_pkg::PTR_W;

    lsht_pkg::rec_t slot_mem [lsht_pkg::TABLE_SIZE];
    logic [PW-1:0]  bkt_mem  [lsht_pkg::TABLE_SIZE];
    logic [15:0]    bl_mem   [lsht_pkg::TABLE_SIZE * lsht_pkg::BL_DEPTH];

    lsht_pkg::op_t  op_reg;
    logic [31:0]    addr_reg;
    logic [15:0]    port_reg;
    logic [SW-1:0]  slot_reg;
    logic [15:0]    conn_reg;

    logic [31:0] ha_reg, hb_reg, hc_reg, ha_next, hb_next, hc_next;
    logic [lsht_pkg::HSTEP_W-1:0] hstep_reg;
    logic [SW-1:0]  bkt_reg;
    logic [PW-1:0]  head_reg;
    logic [PW-1:0]  ptr_reg, ptr_next;
    logic [PW-1:0]  free_head_reg, free_head_next;
    logic [SW-1:0]  fslot_reg;
    logic [PW-1:0]  sav_pv_reg, sav_nx_reg;
    lsht_pkg::rec_t rec_reg, wdata;
    logic           slot_we;
    logic [15:0]    bl_rd_reg;
    logic [lsht_pkg::BL_IDX_W-1:0] bl_wr_idx;

    logic           bkt_we;
    logic [SW-1:0]  bkt_waddr;
    logic [PW-1:0]  bkt_wdata;

    logic           out_valid_reg;
    logic           out_free;
    logic [2:0]     em_status;
    logic [SW-1:0]  em_slot;
    logic [15:0]    em_conn;
    logic           em_flushed, em_freed, em_last;
    logic [4:0]     em_pending;
    logic [2:0]     status_reg;
    logic [SW-1:0]  slot_out_reg;
    logic [15:0]    conn_out_reg;
    logic           flushed_reg, freed_reg, last_reg;
    logic [4:0]     pending_reg;

    // Hash unit: one mixing step of the final round per cycle
    always_comb
    begin
        ha_next = ha_reg;
        hb_next = hb_reg;
        hc_next = hc_reg;
        case (hstep_reg)
            3'd0:    hc_next = (hc_reg ^ hb_reg) - lsht_pkg::rotl32(hb_reg, 5'd14);
            3'd1:    ha_next = (ha_reg ^ hc_reg) - lsht_pkg::rotl32(hc_reg, 5'd11);
            3'd2:    hb_next = (hb_reg ^ ha_reg) - lsht_pkg::rotl32(ha_reg, 5'd25);
            3'd3:    hc_next = (hc_reg ^ hb_reg) - lsht_pkg::rotl32(hb_reg, 5'd16);
            3'd4:    ha_next = (ha_reg ^ hc_reg) - lsht_pkg::rotl32(hc_reg, 5'd4);
            3'd5:    hb_next = (hb_reg ^ ha_reg) - lsht_pkg::rotl32(ha_reg, 5'd14);
            3'd6:    hc_next = (hc_reg ^ hb_reg) - lsht_pkg::rotl32(hb_reg, 5'd24);
            default: hc_next = hc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= lsht_pkg::op_t'(op);
            addr_reg  <= addr;
            port_reg  <= port;
            slot_reg  <= slot;
            conn_reg  <= conn;
            ha_reg    <= lsht_pkg::JH_INIT + addr;
            hb_reg    <= lsht_pkg::JH_INIT + {16'd0, port};
            hc_reg    <= lsht_pkg::JH_INIT;
            hstep_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            ha_reg    <= ha_next;
            hb_reg    <= hb_next;
            hc_reg    <= hc_next;
            hstep_reg <= hstep_reg + 1'b1;
            bkt_reg   <= hc_next[SW-1:0];
        end
        if (cmd.fslot_load)
        begin
            fslot_reg <= free_head_reg[SW-1:0];
        end
        if (cmd.sav_load)
        begin
            sav_pv_reg <= rec_reg.prev;
            sav_nx_reg <= rec_reg.next;
        end
    end

    // Record pointer
    always_comb
    begin
        case (cmd.ptr_sel)
            lsht_pkg::PTR_HOLD: ptr_next = ptr_reg;
            lsht_pkg::PTR_INC:  ptr_next = ptr_reg + 1'b1;
            lsht_pkg::PTR_HEAD: ptr_next = head_reg;
            lsht_pkg::PTR_NEXT: ptr_next = rec_reg.next;
            lsht_pkg::PTR_SLOT: ptr_next = {1'b0, slot_reg};
            lsht_pkg::PTR_FREE: ptr_next = free_head_reg;
            lsht_pkg::PTR_PV:   ptr_next = sav_pv_reg;
            lsht_pkg::PTR_NX:   ptr_next = sav_nx_reg;
            default:            ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.fh_sel)
            lsht_pkg::FH_POP:  free_head_next = rec_reg.free_next;
            lsht_pkg::FH_PUSH: free_head_next = {1'b0, slot_reg};
            default:           free_head_next = free_head_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            free_head_reg <= '0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            free_head_reg <= free_head_next;
        end
    end

    // Record edits, always at the current pointer
    always_comb
    begin
        wdata = rec_reg;
        case (cmd.wr_sel)
            lsht_pkg::W_CLEAR:
            begin
                wdata.key_addr  = '0;
                wdata.key_port  = '0;
                wdata.next      = lsht_pkg::NONE;
                wdata.prev      = lsht_pkg::NONE;
                wdata.home      = lsht_pkg::NONE;
                wdata.ref_cnt   = '0;
                wdata.free_next = ptr_reg + 1'b1;
                wdata.bl_rd     = '0;
                wdata.bl_cnt    = '0;
            end
            lsht_pkg::W_CREATE:
            begin
                wdata.key_addr = addr_reg;
                wdata.key_port = port_reg;
                wdata.next     = head_reg;
                wdata.prev     = lsht_pkg::NONE;
                wdata.home     = {1'b0, bkt_reg};
                wdata.ref_cnt  = 8'd1;
                wdata.bl_rd    = '0;
                wdata.bl_cnt   = '0;
            end
            lsht_pkg::W_REF_INC:     wdata.ref_cnt = rec_reg.ref_cnt + 1'b1;
            lsht_pkg::W_REF_DEC:     wdata.ref_cnt = rec_reg.ref_cnt - 1'b1;
            lsht_pkg::W_SET_PREV_F:  wdata.prev = {1'b0, fslot_reg};
            lsht_pkg::W_SET_NEXT_NX: wdata.next = sav_nx_reg;
            lsht_pkg::W_SET_PREV_PV: wdata.prev = sav_pv_reg;
            lsht_pkg::W_UNLINK_SELF:
            begin
                wdata.next = lsht_pkg::NONE;
                wdata.prev = lsht_pkg::NONE;
                wdata.home = lsht_pkg::NONE;
            end
            lsht_pkg::W_BL_PUSH:     wdata.bl_cnt = rec_reg.bl_cnt + 1'b1;
            lsht_pkg::W_BL_POP:
            begin
                wdata.bl_rd  = rec_reg.bl_rd + 1'b1;
                wdata.bl_cnt = rec_reg.bl_cnt - 1'b1;
            end
            lsht_pkg::W_FREE:
            begin
                wdata.key_addr  = '0;
                wdata.key_port  = '0;
                wdata.free_next = free_head_reg;
                wdata.bl_rd     = '0;
                wdata.bl_cnt    = '0;
            end
            default: wdata = rec_reg;
        endcase
    end

    assign slot_we = (cmd.wr_sel != lsht_pkg::W_NONE);

    // Slot records: write-through so an edited record reads back at once
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[ptr_reg[SW-1:0]] <= wdata;
            rec_reg <= wdata;
        end
        else
        begin
            rec_reg <= slot_mem[ptr_reg[SW-1:0]];
        end
    end

    // Bucket heads
    always_comb
    begin
        bkt_we    = 1'b1;
        bkt_waddr = ptr_reg[SW-1:0];
        bkt_wdata = lsht_pkg::NONE;
        case (cmd.bkt_wr)
            lsht_pkg::B_CLEAR:  bkt_waddr = ptr_reg[SW-1:0];
            lsht_pkg::B_CREATE:
            begin
                bkt_waddr = bkt_reg;
                bkt_wdata = {1'b0, fslot_reg};
            end
            lsht_pkg::B_UNLINK:
            begin
                bkt_waddr = rec_reg.home[SW-1:0];
                bkt_wdata = rec_reg.next;
            end
            default: bkt_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        head_reg <= bkt_mem[bkt_reg];
    end

    // Backlog rings, one per slot
    assign bl_wr_idx = rec_reg.bl_rd + rec_reg.bl_cnt[lsht_pkg::BL_IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.bl_push)
        begin
            bl_mem[{ptr_reg[SW-1:0], bl_wr_idx}] <= conn_reg;
        end
        bl_rd_reg <= bl_mem[{ptr_reg[SW-1:0], rec_reg.bl_rd}];
    end

    // Result fields
    always_comb
    begin
        em_status  = lsht_pkg::STAT_OK;
        em_slot    = slot_reg;
        em_conn    = '0;
        em_flushed = 1'b0;
        em_freed   = 1'b0;
        em_pending = rec_reg.bl_cnt;
        em_last    = 1'b1;
        case (cmd.emit)
            lsht_pkg::EM_LOOKUP_OK: em_slot = ptr_reg[SW-1:0];
            lsht_pkg::EM_REFFULL:
            begin
                em_status = lsht_pkg::STAT_REFFULL;
                em_slot   = ptr_reg[SW-1:0];
            end
            lsht_pkg::EM_EXISTS:
            begin
                em_status = lsht_pkg::STAT_EXISTS;
                em_slot   = ptr_reg[SW-1:0];
            end
            lsht_pkg::EM_MISS:
            begin
                em_status  = lsht_pkg::STAT_NOTFOUND;
                em_slot    = '0;
                em_pending = '0;
            end
            lsht_pkg::EM_FULL:
            begin
                em_status  = lsht_pkg::STAT_FULL;
                em_slot    = '0;
                em_pending = '0;
            end
            lsht_pkg::EM_CREATED:
            begin
                em_slot    = fslot_reg;
                em_pending = '0;
            end
            lsht_pkg::EM_BADSLOT:
            begin
                em_status  = lsht_pkg::STAT_BADSLOT;
                em_pending = '0;
            end
            lsht_pkg::EM_BLFULL:  em_status = lsht_pkg::STAT_BLFULL;
            lsht_pkg::EM_PUSHED:  em_pending = rec_reg.bl_cnt + 1'b1;
            lsht_pkg::EM_BLEMPTY:
            begin
                em_status  = lsht_pkg::STAT_BLEMPTY;
                em_pending = '0;
            end
            lsht_pkg::EM_POPPED:
            begin
                em_conn    = bl_rd_reg;
                em_pending = rec_reg.bl_cnt - 1'b1;
            end
            lsht_pkg::EM_DROPPED: em_pending = rec_reg.bl_cnt;
            lsht_pkg::EM_FLUSH:
            begin
                em_conn    = bl_rd_reg;
                em_flushed = 1'b1;
                em_freed   = 1'b1;
                em_pending = rec_reg.bl_cnt - 1'b1;
                em_last    = 1'b0;
            end
            lsht_pkg::EM_FREED:
            begin
                em_freed   = 1'b1;
                em_pending = '0;
            end
            default: em_last = 1'b1;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit != lsht_pkg::EM_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != lsht_pkg::EM_NONE)
        begin
            status_reg   <= em_status;
            slot_out_reg <= em_slot;
            conn_out_reg <= em_conn;
            flushed_reg  <= em_flushed;
            freed_reg    <= em_freed;
            pending_reg  <= em_pending;
            last_reg     <= em_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign conn_out  = conn_out_reg;
    assign flushed   = flushed_reg;
    assign freed     = freed_reg;
    assign pending   = pending_reg;
    assign last      = last_reg;

    // Status to the controller
    always_comb
    begin
        stat.op          = op_reg;
        stat.hash_last   = (hstep_reg == lsht_pkg::HSTEP_W'(lsht_pkg::HASH_STEPS - 1));
        stat.head_none   = (head_reg == lsht_pkg::NONE);
        stat.key_match   = (rec_reg.key_addr == addr_reg) && (rec_reg.key_port == port_reg);
        stat.next_none   = (rec_reg.next == lsht_pkg::NONE);
        stat.ref_zero    = (rec_reg.ref_cnt == 8'd0);
        stat.ref_one     = (rec_reg.ref_cnt == 8'd1);
        stat.ref_full    = (rec_reg.ref_cnt == lsht_pkg::REF_MAX);
        stat.bl_full     = (rec_reg.bl_cnt >= lsht_pkg::BL_CNT_W'(lsht_pkg::BL_DEPTH));
        stat.bl_empty    = (rec_reg.bl_cnt == '0);
        stat.linked      = (rec_reg.home != lsht_pkg::NONE);
        stat.pv_none     = (rec_reg.prev == lsht_pkg::NONE);
        stat.sav_nx_none = (sav_nx_reg == lsht_pkg::NONE);
        stat.free_none   = (free_head_reg == lsht_pkg::NONE);
        stat.out_free    = out_free;
        stat.clr_last    = (ptr_reg == lsht_pkg::PTR_W'(lsht_pkg::TABLE_SIZE - 1));
    end

endmodule

/* hdl/lsht_ctrl.sv */
// Controller: sequences hashing, chain walks, unlinks, backlog flushes and results.
module lsht_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lsht_pkg::stat_t  stat,
    output lsht_pkg::cmd_t   cmd
);

    lsht_pkg::ctrl_state_t state_reg, state_next;
    logic ul_free_reg, ul_free_next;
    logic is_key_op;

    assign is_key_op = (stat.op == lsht_pkg::OP_CREATE) || (stat.op == lsht_pkg::OP_LOOKUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lsht_pkg::CS_CLEAR;
            ul_free_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ul_free_reg <= ul_free_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        ul_free_next = ul_free_reg;
        case (state_reg)
            lsht_pkg::CS_CLEAR:
                if (stat.clr_last) state_next = lsht_pkg::CS_IDLE;
            lsht_pkg::CS_IDLE:
                if (in_valid) state_next = lsht_pkg::CS_DISPATCH;
            lsht_pkg::CS_DISPATCH:
                case (stat.op)
                    lsht_pkg::OP_CREATE, lsht_pkg::OP_LOOKUP:
                        state_next = lsht_pkg::CS_HASH;
                    lsht_pkg::OP_CLOSE, lsht_pkg::OP_RELEASE,
                    lsht_pkg::OP_PUSH, lsht_pkg::OP_POP:
                        state_next = lsht_pkg::CS_S_WAIT;
                    default: state_next = lsht_pkg::CS_IDLE;
                endcase
            lsht_pkg::CS_HASH:
                if (stat.hash_last) state_next = lsht_pkg::CS_H_WAIT;
            lsht_pkg::CS_H_WAIT: state_next = lsht_pkg::CS_H_CHK;
            lsht_pkg::CS_H_CHK:
                state_next = stat.head_none ? lsht_pkg::CS_MISS : lsht_pkg::CS_WK_WAIT;
            lsht_pkg::CS_WK_WAIT: state_next = lsht_pkg::CS_WK_CMP;
            lsht_pkg::CS_WK_CMP:
                if (stat.key_match) state_next = lsht_pkg::CS_FOUND;
                else if (stat.next_none) state_next = lsht_pkg::CS_MISS;
                else state_next = lsht_pkg::CS_WK_WAIT;
            lsht_pkg::CS_FOUND:
                if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
            lsht_pkg::CS_MISS:
                if (stat.op == lsht_pkg::OP_LOOKUP || stat.free_none)
                begin
                    if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
                end
                else
                begin
                    state_next = lsht_pkg::CS_C_WAIT;
                end
            lsht_pkg::CS_C_WAIT: state_next = lsht_pkg::CS_C_WR;
            lsht_pkg::CS_C_WR:
                state_next = stat.head_none ? lsht_pkg::CS_C_EMIT : lsht_pkg::CS_C_HWAIT;
            lsht_pkg::CS_C_HWAIT: state_next = lsht_pkg::CS_C_HWR;
            lsht_pkg::CS_C_HWR:   state_next = lsht_pkg::CS_C_EMIT;
            lsht_pkg::CS_C_EMIT:
                if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
            lsht_pkg::CS_S_WAIT: state_next = lsht_pkg::CS_S_CHK;
            lsht_pkg::CS_S_CHK:
                if (stat.ref_zero)
                begin
                    if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
                end
                else
                begin
                    case (stat.op)
                        lsht_pkg::OP_CLOSE:
                        begin
                            state_next   = lsht_pkg::CS_U_CHK;
                            ul_free_next = 1'b0;
                        end
                        lsht_pkg::OP_RELEASE: state_next = lsht_pkg::CS_DROP;
                        lsht_pkg::OP_POP:
                            if (!stat.bl_empty) state_next = lsht_pkg::CS_P_EMIT;
                            else if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
                        default:
                            if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
                    endcase
                end
            lsht_pkg::CS_P_EMIT:
                if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
            lsht_pkg::CS_DROP:
                if (stat.ref_one) state_next = lsht_pkg::CS_F_CHK;
                else if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
            lsht_pkg::CS_F_CHK:
                if (stat.bl_empty)
                begin
                    state_next   = lsht_pkg::CS_U_CHK;
                    ul_free_next = 1'b1;
                end
                else
                begin
                    state_next = lsht_pkg::CS_F_EMIT;
                end
            lsht_pkg::CS_F_EMIT:
                if (stat.out_free) state_next = lsht_pkg::CS_F_CHK;
            lsht_pkg::CS_U_CHK:
                if (!stat.linked)
                    state_next = ul_free_reg ? lsht_pkg::CS_FREE : lsht_pkg::CS_DROP;
                else if (stat.pv_none)
                    state_next = lsht_pkg::CS_U_NX;
                else
                    state_next = lsht_pkg::CS_U_PV_WAIT;
            lsht_pkg::CS_U_PV_WAIT: state_next = lsht_pkg::CS_U_PV_WR;
            lsht_pkg::CS_U_PV_WR:   state_next = lsht_pkg::CS_U_NX;
            lsht_pkg::CS_U_NX:
                state_next = stat.sav_nx_none ? lsht_pkg::CS_U_SELF : lsht_pkg::CS_U_NX_WAIT;
            lsht_pkg::CS_U_NX_WAIT:   state_next = lsht_pkg::CS_U_NX_WR;
            lsht_pkg::CS_U_NX_WR:     state_next = lsht_pkg::CS_U_SELF;
            lsht_pkg::CS_U_SELF:      state_next = lsht_pkg::CS_U_SELF_WAIT;
            lsht_pkg::CS_U_SELF_WAIT: state_next = lsht_pkg::CS_U_SELF_WR;
            lsht_pkg::CS_U_SELF_WR:
                state_next = ul_free_reg ? lsht_pkg::CS_FREE : lsht_pkg::CS_DROP;
            lsht_pkg::CS_FREE:
                if (stat.out_free) state_next = lsht_pkg::CS_IDLE;
            default: state_next = lsht_pkg::CS_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd.capture    = 1'b0;
        cmd.hash_step  = 1'b0;
        cmd.ptr_sel    = lsht_pkg::PTR_HOLD;
        cmd.wr_sel     = lsht_pkg::W_NONE;
        cmd.bkt_wr     = lsht_pkg::B_NONE;
        cmd.fh_sel     = lsht_pkg::FH_HOLD;
        cmd.fslot_load = 1'b0;
        cmd.sav_load   = 1'b0;
        cmd.bl_push    = 1'b0;
        cmd.emit       = lsht_pkg::EM_NONE;
        in_stall       = 1'b1;
        case (state_reg)
            lsht_pkg::CS_CLEAR:
            begin
                cmd.ptr_sel = lsht_pkg::PTR_INC;
                cmd.wr_sel  = lsht_pkg::W_CLEAR;
                cmd.bkt_wr  = lsht_pkg::B_CLEAR;
            end
            lsht_pkg::CS_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            lsht_pkg::CS_DISPATCH:
                if (!is_key_op) cmd.ptr_sel = lsht_pkg::PTR_SLOT;
            lsht_pkg::CS_HASH: cmd.hash_step = 1'b1;
            lsht_pkg::CS_H_CHK:
                if (!stat.head_none) cmd.ptr_sel = lsht_pkg::PTR_HEAD;
            lsht_pkg::CS_WK_CMP:
                if (!stat.key_match && !stat.next_none) cmd.ptr_sel = lsht_pkg::PTR_NEXT;
            lsht_pkg::CS_FOUND:
                if (stat.out_free)
                begin
                    if (stat.op == lsht_pkg::OP_LOOKUP)
                    begin
                        if (stat.ref_full)
                        begin
                            cmd.emit = lsht_pkg::EM_REFFULL;
                        end
                        else
                        begin
                            cmd.emit   = lsht_pkg::EM_LOOKUP_OK;
                            cmd.wr_sel = lsht_pkg::W_REF_INC;
                        end
                    end
                    else
                    begin
                        cmd.emit = lsht_pkg::EM_EXISTS;
                    end
                end
            lsht_pkg::CS_MISS:
                if (stat.op == lsht_pkg::OP_LOOKUP)
                begin
                    if (stat.out_free) cmd.emit = lsht_pkg::EM_MISS;
                end
                else if (stat.free_none)
                begin
                    if (stat.out_free) cmd.emit = lsht_pkg::EM_FULL;
                end
                else
                begin
                    cmd.ptr_sel    = lsht_pkg::PTR_FREE;
                    cmd.fslot_load = 1'b1;
                end
            lsht_pkg::CS_C_WR:
            begin
                cmd.wr_sel = lsht_pkg::W_CREATE;
                cmd.fh_sel = lsht_pkg::FH_POP;
                cmd.bkt_wr = lsht_pkg::B_CREATE;
                if (!stat.head_none) cmd.ptr_sel = lsht_pkg::PTR_HEAD;
            end
            lsht_pkg::CS_C_HWR: cmd.wr_sel = lsht_pkg::W_SET_PREV_F;
            lsht_pkg::CS_C_EMIT:
                if (stat.out_free) cmd.emit = lsht_pkg::EM_CREATED;
            lsht_pkg::CS_S_CHK:
                if (stat.ref_zero)
                begin
                    if (stat.out_free) cmd.emit = lsht_pkg::EM_BADSLOT;
                end
                else if (stat.op == lsht_pkg::OP_PUSH)
                begin
                    if (stat.out_free)
                    begin
                        if (stat.bl_full)
                        begin
                            cmd.emit = lsht_pkg::EM_BLFULL;
                        end
                        else
                        begin
                            cmd.emit    = lsht_pkg::EM_PUSHED;
                            cmd.wr_sel  = lsht_pkg::W_BL_PUSH;
                            cmd.bl_push = 1'b1;
                        end
                    end
                end
                else if (stat.op == lsht_pkg::OP_POP && stat.bl_empty)
                begin
                    if (stat.out_free) cmd.emit = lsht_pkg::EM_BLEMPTY;
                end
            lsht_pkg::CS_P_EMIT:
                if (stat.out_free)
                begin
                    cmd.emit   = lsht_pkg::EM_POPPED;
                    cmd.wr_sel = lsht_pkg::W_BL_POP;
                end
            lsht_pkg::CS_DROP:
                if (stat.ref_one)
                begin
                    cmd.wr_sel = lsht_pkg::W_REF_DEC;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = lsht_pkg::EM_DROPPED;
                    cmd.wr_sel = lsht_pkg::W_REF_DEC;
                end
            lsht_pkg::CS_F_EMIT:
                if (stat.out_free)
                begin
                    cmd.emit   = lsht_pkg::EM_FLUSH;
                    cmd.wr_sel = lsht_pkg::W_BL_POP;
                end
            lsht_pkg::CS_U_CHK:
                if (stat.linked)
                begin
                    cmd.sav_load = 1'b1;
                    if (stat.pv_none) cmd.bkt_wr = lsht_pkg::B_UNLINK;
                    else cmd.ptr_sel = lsht_pkg::PTR_PV;
                end
            lsht_pkg::CS_U_PV_WR: cmd.wr_sel = lsht_pkg::W_SET_NEXT_NX;
            lsht_pkg::CS_U_NX:
                if (!stat.sav_nx_none) cmd.ptr_sel = lsht_pkg::PTR_NX;
            lsht_pkg::CS_U_NX_WR:   cmd.wr_sel = lsht_pkg::W_SET_PREV_PV;
            lsht_pkg::CS_U_SELF:    cmd.ptr_sel = lsht_pkg::PTR_SLOT;
            lsht_pkg::CS_U_SELF_WR: cmd.wr_sel = lsht_pkg::W_UNLINK_SELF;
            lsht_pkg::CS_FREE:
                if (stat.out_free)
                begin
                    cmd.emit   = lsht_pkg::EM_FREED;
                    cmd.wr_sel = lsht_pkg::W_FREE;
                    cmd.fh_sel = lsht_pkg::FH_PUSH;
                end
            default: in_stall = 1'b1;
        endcase
    end

endmodule

/* hdl/listen_socket_hash_table.sv */
// Listening-socket hash table: 64-slot pool, bucket chains, reference counts, backlogs.
//
// Input channel (in_valid/in_stall) takes one operation per transfer: create,
// lookup_acquire, close, release, push_conn or pop_conn. Output channel
// (out_valid/out_stall) returns the results; the last one of an operation has
// last set. Freeing a slot first returns one flushed result per backlog entry.
// The block works on one operation at a time. Create and lookup hash the key
// with the one-step-per-cycle hash unit, then walk the bucket chain through
// the single read port of the slot record memory; a create that takes a slot
// then writes the new record and links it in front of the old bucket head.
// Close and release may also unlink the slot and flush its backlog.
// After reset a clearing pass initialises the 64 slot records and bucket
// heads; in_stall stays high during it. Results wait in an output
// register: while the receiver stalls, the block holds the result and the
// operation in flight, then advances on the next transfer.
module listen_socket_hash_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [31:0] addr,
    input  logic [15:0] port,
    input  logic [5:0]  slot,
    input  logic [15:0] conn,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [5:0]  slot_out,
    output logic [15:0] conn_out,
    output logic        flushed,
    output logic        freed,
    output logic [4:0]  pending,
    output logic        last
);

    lsht_pkg::cmd_t  cmd;
    lsht_pkg::stat_t stat;

    lsht_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lsht_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .op        (op),
        .addr      (addr),
        .port      (port),
        .slot      (slot),
        .conn      (conn),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot_out  (slot_out),
        .conn_out  (conn_out),
        .flushed   (flushed),
        .freed     (freed),
        .pending   (pending),
        .last      (last)
    );

`ifndef NO_ASSERTIONS
    a_flush_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flushed |-> freed && !last)
        else $error("flushed result must be freed and not last");

    a_free_final_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && freed && last |-> pending == 5'd0 && status == lsht_pkg::STAT_OK)
        else $error("final freed result must show an empty backlog");

    a_error_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != lsht_pkg::STAT_OK |-> !flushed && !freed && last)
        else $error("error result must be single and must not free");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second operation taken while one is in flight");
`endif

endmodule

/* bench/tb_listen_socket_hash_table.sv */
// Self-checking testbench for the listening-socket hash table.
module tb_listen_socket_hash_table;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_out;
        logic [15:0] conn_out;
        logic        flushed;
        logic        freed;
        logic [4:0]  pending;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  op = '0;
    logic [31:0] addr = '0;
    logic [15:0] port = '0;
    logic [5:0]  slot = '0;
    logic [15:0] conn = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [5:0]  slot_out;
    logic [15:0] conn_out;
    logic        flushed;
    logic        freed;
    logic [4:0]  pending;
    logic        last;

    listen_socket_hash_table i_dut (.*);

    always #5 clk = ~clk;

    // Shadow copy of the table
    logic [31:0] sh_addr [lsht_pkg::TABLE_SIZE];
    logic [15:0] sh_port [lsht_pkg::TABLE_SIZE];
    int          sh_next [lsht_pkg::TABLE_SIZE];
    int          sh_prev [lsht_pkg::TABLE_SIZE];
    int          sh_home [lsht_pkg::TABLE_SIZE];
    int          sh_refs [lsht_pkg::TABLE_SIZE];
    int          sh_fnext[lsht_pkg::TABLE_SIZE];
    int          sh_head [lsht_pkg::TABLE_SIZE];
    int          sh_fhead;
    logic [15:0] sh_bl   [lsht_pkg::TABLE_SIZE][lsht_pkg::BL_DEPTH];
    int          sh_rd   [lsht_pkg::TABLE_SIZE];
    int          sh_cnt  [lsht_pkg::TABLE_SIZE];

    result_t     expected_results[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_off = 1'b0;
    // keys sent in creates, so lookups and duplicate creates can hit
    logic [47:0] known_keys[$];

    function automatic int jbucket(logic [31:0] ka, logic [15:0] kp);
        logic [31:0] a, b, c;
        a = 32'hDEADBEF5; b = a; c = a;
        a += ka; b += {16'd0, kp};
        c ^= b; c -= {b[17:0], b[31:18]};
        a ^= c; a -= {c[20:0], c[31:21]};
        b ^= a; b -= {a[6:0], a[31:7]};
        c ^= b; c -= {b[15:0], b[31:16]};
        a ^= c; a -= {c[27:0], c[31:28]};
        b ^= a; b -= {a[17:0], a[31:18]};
        c ^= b; c -= {b[7:0], b[31:8]};
        return c % lsht_pkg::TABLE_SIZE;
    endfunction

    function automatic void queue_result(int st, int s, int c, int fl, int fr, int pd,
                                         int lst);
        result_t r;
        r.status = st[2:0]; r.slot_out = s[5:0]; r.conn_out = c[15:0];
        r.flushed = fl[0]; r.freed = fr[0]; r.pending = pd[4:0]; r.last = lst[0];
        expected_results.push_back(r);
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < lsht_pkg::TABLE_SIZE; i++)
        begin
            sh_addr[i] = '0; sh_port[i] = '0;
            sh_next[i] = lsht_pkg::TABLE_SIZE; sh_prev[i] = lsht_pkg::TABLE_SIZE;
            sh_home[i] = lsht_pkg::TABLE_SIZE;
            sh_refs[i] = 0; sh_fnext[i] = i + 1; sh_head[i] = lsht_pkg::TABLE_SIZE;
            sh_rd[i] = 0; sh_cnt[i] = 0;
        end
        sh_fhead = 0;
    endfunction

    function automatic void unlink(int s);
        int b, nx, pv;
        b = sh_home[s]; nx = sh_next[s]; pv = sh_prev[s];
        if (b >= lsht_pkg::TABLE_SIZE)
            return;
        if (pv < lsht_pkg::TABLE_SIZE)
            sh_next[pv] = nx;
        else
            sh_head[b] = nx;
        if (nx < lsht_pkg::TABLE_SIZE)
            sh_prev[nx] = pv;
        sh_next[s] = lsht_pkg::TABLE_SIZE; sh_prev[s] = lsht_pkg::TABLE_SIZE;
        sh_home[s] = lsht_pkg::TABLE_SIZE;
    endfunction

    function automatic void drop_reference(int s);
        sh_refs[s]--;
        if (sh_refs[s] != 0)
        begin
            queue_result(lsht_pkg::STAT_OK, s, 0, 0, 0, sh_cnt[s], 1);
            return;
        end
        while (sh_cnt[s] > 0)
        begin
            logic [15:0] c;
            c = sh_bl[s][sh_rd[s]];
            sh_rd[s] = (sh_rd[s] + 1) % lsht_pkg::BL_DEPTH;
            sh_cnt[s]--;
            queue_result(lsht_pkg::STAT_OK, s, c, 1, 1, sh_cnt[s], 0);
        end
        unlink(s);
        sh_addr[s] = '0; sh_port[s] = '0; sh_rd[s] = 0; sh_cnt[s] = 0;
        sh_fnext[s] = sh_fhead; sh_fhead = s;
        queue_result(lsht_pkg::STAT_OK, s, 0, 0, 1, 0, 1);
    endfunction

    function automatic void predict_table_op(logic [2:0] o, logic [31:0] a, logic [15:0] p,
                                             int s, logic [15:0] c);
        int b, f, cur, guard;
        if (o == lsht_pkg::OP_CREATE || o == lsht_pkg::OP_LOOKUP)
        begin
            b = jbucket(a, p);
            f = lsht_pkg::TABLE_SIZE; cur = sh_head[b]; guard = 0;
            while (cur < lsht_pkg::TABLE_SIZE && guard < lsht_pkg::TABLE_SIZE)
            begin
                if (sh_addr[cur] == a && sh_port[cur] == p)
                begin
                    f = cur;
                    break;
                end
                cur = sh_next[cur];
                guard++;
            end
            if (o == lsht_pkg::OP_LOOKUP)
            begin
                if (f >= lsht_pkg::TABLE_SIZE)
                    queue_result(lsht_pkg::STAT_NOTFOUND, 0, 0, 0, 0, 0, 1);
                else if (sh_refs[f] == 255)
                    queue_result(lsht_pkg::STAT_REFFULL, f, 0, 0, 0, sh_cnt[f], 1);
                else
                begin
                    sh_refs[f]++;
                    queue_result(lsht_pkg::STAT_OK, f, 0, 0, 0, sh_cnt[f], 1);
                end
            end
            else if (f < lsht_pkg::TABLE_SIZE)
                queue_result(lsht_pkg::STAT_EXISTS, f, 0, 0, 0, sh_cnt[f], 1);
            else if (sh_fhead >= lsht_pkg::TABLE_SIZE)
                queue_result(lsht_pkg::STAT_FULL, 0, 0, 0, 0, 0, 1);
            else
            begin
                f = sh_fhead; sh_fhead = sh_fnext[f];
                sh_addr[f] = a; sh_port[f] = p;
                sh_next[f] = sh_head[b]; sh_prev[f] = lsht_pkg::TABLE_SIZE;
                if (sh_head[b] < lsht_pkg::TABLE_SIZE)
                    sh_prev[sh_head[b]] = f;
                sh_head[b] = f; sh_home[f] = b;
                sh_refs[f] = 1; sh_rd[f] = 0; sh_cnt[f] = 0;
                queue_result(lsht_pkg::STAT_OK, f, 0, 0, 0, 0, 1);
            end
            return;
        end
        if (o > lsht_pkg::OP_POP)
            return;
        if (sh_refs[s] == 0)
            queue_result(lsht_pkg::STAT_BADSLOT, s, 0, 0, 0, 0, 1);
        else if (o == lsht_pkg::OP_CLOSE)
        begin
            unlink(s);
            drop_reference(s);
        end
        else if (o == lsht_pkg::OP_RELEASE)
            drop_reference(s);
        else if (o == lsht_pkg::OP_PUSH)
        begin
            if (sh_cnt[s] >= lsht_pkg::BL_DEPTH)
                queue_result(lsht_pkg::STAT_BLFULL, s, 0, 0, 0, sh_cnt[s], 1);
            else
            begin
                sh_bl[s][(sh_rd[s] + sh_cnt[s]) % lsht_pkg::BL_DEPTH] = c;
                sh_cnt[s]++;
                queue_result(lsht_pkg::STAT_OK, s, 0, 0, 0, sh_cnt[s], 1);
            end
        end
        else if (sh_cnt[s] == 0)
            queue_result(lsht_pkg::STAT_BLEMPTY, s, 0, 0, 0, 0, 1);
        else
        begin
            logic [15:0] v;
            v = sh_bl[s][sh_rd[s]];
            sh_rd[s] = (sh_rd[s] + 1) % lsht_pkg::BL_DEPTH;
            sh_cnt[s]--;
            queue_result(lsht_pkg::STAT_OK, s, v, 0, 0, sh_cnt[s], 1);
        end
    endfunction

    // Drive one operation and hold it until the transfer completes
    task automatic send_op(logic [2:0] o, logic [31:0] a, logic [15:0] p, logic [5:0] s,
                           logic [15:0] c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        op <= o; addr <= a; port <= p; slot <= s; conn <= c;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_table_op(o, a, p, s, c);
        if (o == lsht_pkg::OP_CREATE)
            known_keys.push_back({a, p});
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Pick a slot that is probably live
    function automatic logic [5:0] pick_slot();
        for (int t = 0; t < 8; t++)
        begin
            int s;
            s = $urandom_range(lsht_pkg::TABLE_SIZE - 1);
            if (sh_refs[s] != 0)
                return s[5:0];
        end
        return 6'($urandom_range(lsht_pkg::TABLE_SIZE - 1));
    endfunction

    task automatic send_random_op();
        logic [47:0] k;
        int          pick;
        pick = $urandom_range(99);
        k = {$urandom, 16'($urandom)};
        if (known_keys.size() > 0 && $urandom_range(2) != 0)
            k = known_keys[$urandom_range(known_keys.size() - 1)];
        if (pick < 18)
            send_op(lsht_pkg::OP_CREATE, k[47:16], k[15:0], 6'($urandom), 16'($urandom));
        else if (pick < 33)
            send_op(lsht_pkg::OP_LOOKUP, k[47:16], k[15:0], 6'($urandom), 16'($urandom));
        else if (pick < 41)
            send_op(lsht_pkg::OP_CLOSE, $urandom, 16'($urandom), pick_slot(), 16'($urandom));
        else if (pick < 49)
            send_op(lsht_pkg::OP_RELEASE, $urandom, 16'($urandom), pick_slot(),
                    16'($urandom));
        else if (pick < 77)
            send_op(lsht_pkg::OP_PUSH, $urandom, 16'($urandom), pick_slot(), 16'($urandom));
        else if (pick < 95)
            send_op(lsht_pkg::OP_POP, $urandom, 16'($urandom), pick_slot(), 16'($urandom));
        else
            send_op(3'($urandom_range(7, 6)), $urandom, 16'($urandom), 6'($urandom),
                    16'($urandom));
    endtask

    task automatic test_directed();
        send_op(lsht_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 6'd0, 16'd0);
        send_op(lsht_pkg::OP_POP, '0, '0, 6'd63, '0);
        send_op(lsht_pkg::OP_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 6'd0, 16'd0);
        send_op(lsht_pkg::OP_CREATE, 32'h0, 16'h0, 6'd0, 16'd0);
        send_op(lsht_pkg::OP_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 6'd0, 16'd0);
        send_op(lsht_pkg::OP_LOOKUP, 32'h0, 16'h0, 6'd0, 16'd0);
        send_op(lsht_pkg::OP_POP, '0, '0, 6'd1, '0);
        send_op(lsht_pkg::OP_PUSH, '0, '0, 6'd1, 16'hFFFF);
        send_op(lsht_pkg::OP_PUSH, '0, '0, 6'd1, 16'h0);
        send_op(lsht_pkg::OP_POP, '0, '0, 6'd1, '0);
        send_op(3'd6, '0, '0, 6'd1, '0);
        send_op(3'd7, '0, '0, 6'd1, '0);
        send_op(lsht_pkg::OP_CLOSE, '0, '0, 6'd1, '0);
        send_op(lsht_pkg::OP_CLOSE, '0, '0, 6'd1, '0);
        send_op(lsht_pkg::OP_LOOKUP, 32'h0, 16'h0, 6'd0, 16'd0);
        for (int i = 0; i < lsht_pkg::BL_DEPTH + 1; i++)
            send_op(lsht_pkg::OP_PUSH, '0, '0, 6'd0, 16'($urandom));
        send_op(lsht_pkg::OP_RELEASE, '0, '0, 6'd0, '0);
        send_op(lsht_pkg::OP_RELEASE, '0, '0, 6'd0, '0);
    endtask

    // Fill the pool past its end, then close every slot
    task automatic test_pool_full();
        for (int i = 0; i < lsht_pkg::TABLE_SIZE + 1; i++)
            send_op(lsht_pkg::OP_CREATE, 32'h0A00_0000 + i, 16'd80, '0, '0);
        for (int i = 0; i < lsht_pkg::TABLE_SIZE; i++)
            send_op(lsht_pkg::OP_CLOSE, '0, '0, 6'(i), '0);
        wait (expected_results.size() == 0);
    endtask

    task automatic test_long_hold_off();
        hold_off <= 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off <= 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_random_op();
        join
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
            send_random_op();
    endtask

    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_t got, want;
            got = {status, slot_out, conn_out, flushed, freed, pending, last};
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: expected st=%0d slot=%0d conn=%h fl=%b fr=%b pend=%0d last=%b",
                             $time, want.status, want.slot_out, want.conn_out, want.flushed,
                             want.freed, want.pending, want.last);
                    $display("%0t: actual   st=%0d slot=%0d conn=%h fl=%b fr=%b pend=%0d last=%b",
                             $time, got.status, got.slot_out, got.conn_out, got.flushed,
                             got.freed, got.pending, got.last);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        table_reset();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_pool_full();
        test_random(40, 0, 0);
        test_long_hold_off();
        test_random(32, 49, 0);
        test_random(32, 0, 49);
        test_random(32, 18, 18);
        stall_pct = 0;
        wait (expected_results.size() == 0);
        repeat (50) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
